/* hw/rtl/assert_macros.svh */
// assertion macros shared by the evaluator rtl
// expects clk_i and rst_ni in the scope of the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside reset
`define IEE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked on every rising edge including reset
`define IEE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* hw/rtl/iee_pkg.sv */
// types and constants of the infix expression evaluator
// used by every module of the block, no dependencies
`default_nettype none

package iee_pkg;

  localparam int Width     = 64;
  localparam int CntW      = $clog2(Width);
  localparam int MaxDigits = 19;
  localparam int DigitCntW = 5;

  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);

  typedef struct packed {
    logic [7:0] char_code;
  } char_t;

  typedef struct packed {
    logic signed [Width-1:0] value;
    logic                    div_zero;
    logic                    too_long;
  } res_t;

  typedef enum logic [2:0] {
    TokDigit,
    TokAdd,
    TokSub,
    TokMul,
    TokDiv,
    TokEnd
  } tok_kind_e;

  typedef struct packed {
    tok_kind_e  kind;
    logic [3:0] digit;
  } tok_t;

  typedef enum logic [1:0] {
    MulNone = 2'd0,
    MulMul  = 2'd1,
    MulDiv  = 2'd2
  } mul_op_e;

  typedef enum logic [1:0] {
    BkIdle,
    BkWait,
    BkApply
  } back_state_e;

  typedef enum logic [1:0] {
    MdIdle,
    MdRun,
    MdDone
  } md_state_e;

  typedef struct packed {
    logic             start;
    logic             op_div;
    logic [Width-1:0] a;
    logic [Width-1:0] b;
  } md_req_t;

  typedef struct packed {
    logic             done;
    logic [Width-1:0] result;
    logic             div_zero;
  } md_rsp_t;

endpackage

`default_nettype wire

/* hw/rtl/iee_stream_if.sv */
// valid/ready stream channel with a typed payload
// no dependencies, the payload type is set where the channel is instantiated
`default_nettype none

interface iee_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/iee_front.sv */
// front end: takes characters and turns them into tokens for the queue
// depends on iee_pkg and iee_stream_if
`default_nettype none

module iee_front (
  iee_stream_if.sink      in_i,
  output logic            push_o,
  output iee_pkg::tok_t   tok_o,
  input  logic            full_i
);
  import iee_pkg::*;

  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharMul   = 8'h78;
  localparam logic [7:0] CharDiv   = 8'h3A;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;

  logic [7:0] ch;

  assign ch = in_i.data.char_code;

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  always_comb begin
    tok_o.digit = 4'(ch - CharZero);
    if (ch >= CharZero && ch <= CharNine) begin
      tok_o.kind = TokDigit;
    end else if (ch == CharPlus) begin
      tok_o.kind = TokAdd;
    end else if (ch == CharMinus) begin
      tok_o.kind = TokSub;
    end else if (ch == CharMul) begin
      tok_o.kind = TokMul;
    end else if (ch == CharDiv) begin
      tok_o.kind = TokDiv;
    end else begin
      tok_o.kind = TokEnd;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/iee_fifo.sv */
// short token queue between front end and execution back end
// depends on iee_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module iee_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  iee_pkg::tok_t tok_i,
  output logic          full_o,
  input  logic          pop_i,
  output iee_pkg::tok_t tok_o,
  output logic          empty_o
);
  import iee_pkg::*;

  tok_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueuePtrW:0]   count_q, count_d;

  assign full_o  = count_q == (QueuePtrW+1)'(QueueDepth);
  assign empty_o = count_q == '0;
  assign tok_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= tok_i;
    end
  end

  `IEE_ASSERT(a_no_push_full, push_i |-> !full_o, "push into full queue")
  `IEE_ASSERT(a_no_pop_empty, pop_i |-> !empty_o, "pop from empty queue")
  `IEE_ASSERT(a_count_tracks, (push_i && !pop_i) |=> !empty_o, "count lost a push")

endmodule

`default_nettype wire

/* hw/rtl/iee_muldiv.sv */
// shared iterative unit: 64-bit wrapping multiply or signed divide, one bit a cycle
// depends on iee_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module iee_muldiv (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  iee_pkg::md_req_t req_i,
  output iee_pkg::md_rsp_t rsp_o
);
  import iee_pkg::*;

  localparam logic [CntW-1:0] LastStep = CntW'(Width - 1);

  md_state_e        state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             is_div_q, is_div_d;
  logic             neg_q, neg_d;
  logic             dz_q, dz_d;
  logic [Width-1:0] x_q, x_d;
  logic [Width-1:0] y_q, y_d;
  logic [Width-1:0] acc_q, acc_d;

  logic [Width-1:0] rem_sh;
  logic [Width:0]   diff;
  logic             b_zero;

  assign b_zero = req_i.b == '0;
  assign rem_sh = {acc_q[Width-2:0], x_q[Width-1]};
  assign diff   = {1'b0, rem_sh} - {1'b0, y_q};

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      MdIdle: begin
        if (req_i.start) begin
          state_d = (req_i.op_div && b_zero) ? MdDone : MdRun;
        end
      end
      MdRun: begin
        if (cnt_q == LastStep) begin
          state_d = MdDone;
        end
      end
      MdDone:  state_d = MdIdle;
      default: state_d = MdIdle;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cnt_d    = cnt_q;
    is_div_d = is_div_q;
    neg_d    = neg_q;
    dz_d     = dz_q;
    x_d      = x_q;
    y_d      = y_q;
    acc_d    = acc_q;
    rsp_o.done     = 1'b0;
    rsp_o.div_zero = dz_q;
    rsp_o.result   = is_div_q ? (neg_q ? '0 - x_q : x_q) : acc_q;
    unique case (state_q)
      MdIdle: begin
        if (req_i.start) begin
          cnt_d    = '0;
          is_div_d = req_i.op_div;
          acc_d    = '0;
          if (req_i.op_div) begin
            // divide on magnitudes, sign fixed on the way out
            neg_d = (req_i.a[Width-1] ^ req_i.b[Width-1]) && !b_zero;
            dz_d  = b_zero;
            x_d   = b_zero ? '0 : (req_i.a[Width-1] ? '0 - req_i.a : req_i.a);
            y_d   = req_i.b[Width-1] ? '0 - req_i.b : req_i.b;
          end else begin
            neg_d = 1'b0;
            dz_d  = 1'b0;
            x_d   = req_i.a;
            y_d   = req_i.b;
          end
        end
      end
      MdRun: begin
        cnt_d = cnt_q + 1'b1;
        if (is_div_q) begin
          if (!diff[Width]) begin
            acc_d = diff[Width-1:0];
            x_d   = {x_q[Width-2:0], 1'b1};
          end else begin
            acc_d = rem_sh;
            x_d   = {x_q[Width-2:0], 1'b0};
          end
        end else begin
          if (y_q[0]) begin
            acc_d = acc_q + x_q;
          end
          x_d = {x_q[Width-2:0], 1'b0};
          y_d = {1'b0, y_q[Width-1:1]};
        end
      end
      MdDone: begin
        rsp_o.done = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MdIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q    <= cnt_d;
    is_div_q <= is_div_d;
    neg_q    <= neg_d;
    dz_q     <= dz_d;
    x_q      <= x_d;
    y_q      <= y_d;
    acc_q    <= acc_d;
  end

  `IEE_ASSERT(a_start_idle, req_i.start |-> state_q == MdIdle, "start while unit busy")
  `IEE_ASSERT(a_done_pulse, rsp_o.done |=> !rsp_o.done, "done held longer than a cycle")
  `IEE_ASSERT(a_dz_result, (rsp_o.done && rsp_o.div_zero) |-> rsp_o.result == '0,
              "zero divisor gave a nonzero quotient")

endmodule

`default_nettype wire

/* hw/rtl/iee_back.sv */
// back end: executes tokens, keeps the accumulators, drives the result register
// depends on iee_pkg, iee_stream_if and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module iee_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  iee_pkg::tok_t    tok_i,
  input  logic             empty_i,
  output logic             pop_o,
  output iee_pkg::md_req_t md_req_o,
  input  iee_pkg::md_rsp_t md_rsp_i,
  iee_stream_if.source     out_o
);
  import iee_pkg::*;

  back_state_e          state_q, state_d;
  logic [Width-1:0]     sum_q, sum_d;
  logic [Width-1:0]     term_q, term_d;
  logic [Width-1:0]     operand_q, operand_d;
  logic                 pend_sub_q, pend_sub_d;
  mul_op_e              pend_mul_q, pend_mul_d;
  logic [DigitCntW-1:0] digit_cnt_q, digit_cnt_d;
  logic                 dz_q, dz_d;
  logic                 ovf_q, ovf_d;
  logic                 out_valid_q, out_valid_d;
  res_t                 out_data_q, out_data_d;

  logic             out_free;
  logic             mul_pending;
  logic [Width-1:0] term_sum;

  assign out_free    = !out_valid_q || out_o.ready;
  assign mul_pending = pend_mul_q == MulMul || pend_mul_q == MulDiv;
  assign term_sum    = pend_sub_q ? sum_q - term_q : sum_q + term_q;

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BkIdle: begin
        if (!empty_i && tok_i.kind != TokDigit) begin
          state_d = mul_pending ? BkWait : BkApply;
        end
      end
      BkWait: begin
        if (md_rsp_i.done) begin
          state_d = BkApply;
        end
      end
      BkApply: begin
        if (tok_i.kind != TokEnd || out_free) begin
          state_d = BkIdle;
        end
      end
      default: state_d = BkIdle;
    endcase
  end

  // datapath and outputs
  always_comb begin
    sum_d       = sum_q;
    term_d      = term_q;
    operand_d   = operand_q;
    pend_sub_d  = pend_sub_q;
    pend_mul_d  = pend_mul_q;
    digit_cnt_d = digit_cnt_q;
    dz_d        = dz_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_data_d  = out_data_q;
    pop_o       = 1'b0;
    md_req_o.start  = 1'b0;
    md_req_o.op_div = pend_mul_q == MulDiv;
    md_req_o.a      = term_q;
    md_req_o.b      = operand_q;
    unique case (state_q)
      BkIdle: begin
        if (!empty_i) begin
          if (tok_i.kind == TokDigit) begin
            pop_o     = 1'b1;
            operand_d = (operand_q << 3) + (operand_q << 1) + Width'(tok_i.digit);
            if (digit_cnt_q < DigitCntW'(MaxDigits)) begin
              digit_cnt_d = digit_cnt_q + 1'b1;
            end else begin
              digit_cnt_d = DigitCntW'(MaxDigits + 1);
              ovf_d       = 1'b1;
            end
          end else if (mul_pending) begin
            md_req_o.start = 1'b1;
          end else begin
            term_d = operand_q;
          end
        end
      end
      BkWait: begin
        if (md_rsp_i.done) begin
          term_d = md_rsp_i.result;
          if (md_rsp_i.div_zero) begin
            dz_d = 1'b1;
          end
        end
      end
      BkApply: begin
        // the finished operand is folded by now
        operand_d   = '0;
        digit_cnt_d = '0;
        pend_mul_d  = MulNone;
        unique case (tok_i.kind)
          TokAdd, TokSub: begin
            pop_o      = 1'b1;
            sum_d      = term_sum;
            term_d     = '0;
            pend_sub_d = tok_i.kind == TokSub;
          end
          TokMul: begin
            pop_o      = 1'b1;
            pend_mul_d = MulMul;
          end
          TokDiv: begin
            pop_o      = 1'b1;
            pend_mul_d = MulDiv;
          end
          TokEnd: begin
            if (out_free) begin
              pop_o               = 1'b1;
              out_valid_d         = 1'b1;
              out_data_d.value    = term_sum;
              out_data_d.div_zero = dz_q;
              out_data_d.too_long = ovf_q;
              sum_d      = '0;
              term_d     = '0;
              pend_sub_d = 1'b0;
              dz_d       = 1'b0;
              ovf_d      = 1'b0;
            end else begin
              // hold the operand state until the result slot frees up
              operand_d   = operand_q;
              digit_cnt_d = digit_cnt_q;
              pend_mul_d  = pend_mul_q;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BkIdle;
      sum_q       <= '0;
      term_q      <= '0;
      operand_q   <= '0;
      pend_sub_q  <= 1'b0;
      pend_mul_q  <= MulNone;
      digit_cnt_q <= '0;
      dz_q        <= 1'b0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      term_q      <= term_d;
      operand_q   <= operand_d;
      pend_sub_q  <= pend_sub_d;
      pend_mul_q  <= pend_mul_d;
      digit_cnt_q <= digit_cnt_d;
      dz_q        <= dz_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  `IEE_ASSERT(a_apply_has_tok, state_q == BkApply |-> !empty_i, "apply without a queued token")
  `IEE_ASSERT(a_done_in_wait, md_rsp_i.done |-> state_q == BkWait, "unit answered unasked")
  `IEE_ASSERT(a_cnt_bound, digit_cnt_q <= DigitCntW'(MaxDigits + 1), "digit count past its cap")

endmodule

`default_nettype wire

/* hw/rtl/infix_expression_evaluator_top.sv */
// Infix expression evaluator: one ASCII character per request on in_i, one
// result per finished expression on out_o (value, div_zero, too_long).
// Digits build a decimal operand, + - x : are operators with x and : binding
// tighter, any other character ends the expression and emits the result.
// The front end classifies characters into a four-entry token queue, so in_i
// keeps accepting while the back end works, until the queue is full.
// Per token: a digit is taken in the idle state, + or - passes from idle to
// apply, and an operator or terminator that follows a pending x or : waits
// for the shared iterative multiply/divide unit, one bit a cycle over 64 bits
// (no iteration with a zero divisor). A result is registered on out_o once
// its terminator is applied at the head of the queue, after any pending
// multiply or divide has been folded in.
// The result sits in an output register; while out_o is stalled the back end
// holds the terminator, the queue fills and in_i drops ready.
// Reset clears the accumulators, the queue and the output valid at once;
// the block takes requests from the first cycle after reset.
// depends on iee_pkg, iee_stream_if and the iee_* submodules
`default_nettype none

module infix_expression_evaluator_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  iee_stream_if.sink   in_i,
  iee_stream_if.source out_o
);
  import iee_pkg::*;

  logic    push;
  tok_t    push_tok;
  logic    full;
  logic    pop;
  tok_t    head_tok;
  logic    empty;
  md_req_t md_req;
  md_rsp_t md_rsp;

  iee_front u_front (
    .in_i   (in_i),
    .push_o (push),
    .tok_o  (push_tok),
    .full_i (full)
  );

  iee_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .tok_i   (push_tok),
    .full_o  (full),
    .pop_i   (pop),
    .tok_o   (head_tok),
    .empty_o (empty)
  );

  iee_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tok_i    (head_tok),
    .empty_i  (empty),
    .pop_o    (pop),
    .md_req_o (md_req),
    .md_rsp_i (md_rsp),
    .out_o    (out_o)
  );

  iee_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .rsp_o  (md_rsp)
  );

endmodule

`default_nettype wire
